FILE: design/php_pkg.sv
// shared types, constants and fixed-point helpers for the pinhole projection block
package php_pkg;

	localparam int XLEN = 32;
	localparam int FRAC = 28;
	localparam int DIV_BITS = 33;
	localparam int NUM_REGS = 8;
	localparam int CFG_IDX_W = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTRE_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RADIAL_K1 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RADIAL_K2 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TANG_P1 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_TANG_P2 = 3'd7;

	localparam logic [31:0] FOCAL_RST = 32'd65536;
	localparam logic signed [34:0] ONE_Q28 = 35'sd268435456;

	// one lane of the restoring divider
	typedef struct packed {
		logic [31:0] mag;
		logic [31:0] den;
		logic [31:0] rem;
		logic [DIV_BITS-1:0] quo;
		logic neg;
		logic ovf;
	} div_lane_t;

	// datapath word carried through the distortion stages
	typedef struct packed {
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic signed [31:0] aa;
		logic signed [31:0] bb;
		logic signed [31:0] ab;
		logic signed [31:0] r2;
		logic signed [31:0] r4;
		logic signed [31:0] r6;
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic signed [31:0] k1r2;
		logic signed [31:0] k2r4;
		logic signed [31:0] k3r6;
		logic signed [31:0] p1ab;
		logic signed [31:0] p2ab;
		logic signed [31:0] p2sx;
		logic signed [31:0] p1sy;
		logic signed [34:0] sum12;
		logic signed [31:0] radial;
		logic signed [31:0] arad;
		logic signed [31:0] brad;
		logic signed [31:0] xd;
		logic signed [31:0] yd;
		logic signed [64:0] pu;
		logic signed [64:0] pv;
		logic signed [31:0] u;
		logic signed [31:0] v;
		logic behind;
		logic clip;
	} geo_t;

	function automatic logic signed [63:0] sx64(input logic [31:0] x);
		return $signed({{32{x[31]}}, x});
	endfunction

	// saturate to signed 32 bits, flag in the top bit
	function automatic logic [32:0] sat32(input logic signed [63:0] x);
		logic [32:0] r;
		if (x > 64'sd2147483647) begin
			r = {1'b1, 32'h7fff_ffff};
		end else if (x < -64'sd2147483648) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, x[31:0]};
		end
		return r;
	endfunction

	// Q4.28 product, floor rounding, saturated
	function automatic logic [32:0] mulq(input logic [31:0] x, input logic [31:0] y);
		logic signed [63:0] p;
		p = sx64(x) * sx64(y);
		return sat32(p >>> FRAC);
	endfunction

	// signed quotient from divider magnitude, saturated
	function automatic logic [32:0] div_sat(input div_lane_t d);
		logic [32:0] r;
		if (d.neg) begin
			if (d.ovf || d.quo > 33'h0_8000_0000) begin
				r = {1'b1, 32'h8000_0000};
			end else begin
				r = {1'b0, 32'(-d.quo)};
			end
		end else begin
			if (d.ovf || d.quo > 33'h0_7fff_ffff) begin
				r = {1'b1, 32'h7fff_ffff};
			end else begin
				r = {1'b0, d.quo[31:0]};
			end
		end
		return r;
	endfunction

endpackage

FILE: design/php_if.sv
// stream interfaces for points in and pixels out
interface php_pt_if;
	logic valid;
	logic ready;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] point_z;
	modport source (output valid, point_x, point_y, point_z, input ready);
	modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

interface php_px_if;
	logic valid;
	logic ready;
	logic signed [31:0] pixel_u;
	logic signed [31:0] pixel_v;
	logic behind_camera;
	logic clipped;
	modport source (output valid, pixel_u, pixel_v, behind_camera, clipped, input ready);
	modport sink (input valid, pixel_u, pixel_v, behind_camera, clipped, output ready);
endinterface

FILE: design/pinhole_projection_with_distortion_top.sv
// Pinhole projection with radial and tangential lens distortion, one point per clock.
// The pipeline has one input stage, a 33-stage restoring divider (one quotient bit
// per stage) for x/z and y/z, and eleven arithmetic stages, at most one multiplier level each.
// Throughput is one transaction per cycle; the whole pipeline holds when the output
// register is full and not taken. Registers are assumed written only while idle.
module pinhole_projection_with_distortion_top #(
	parameter int RADIAL_K3 = 0
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [php_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [31:0] cfg_data,
	php_pt_if.sink in_pt,
	php_px_if.source out_px
);

	localparam int NDIV = php_pkg::DIV_BITS;
	localparam int LAST = NDIV + 12;
	localparam logic [31:0] K3 = 32'(RADIAL_K3);

	logic [31:0] fx_q, fy_q, cx_q, cy_q, k1_q, k2_q, p1_q, p2_q;
	logic en;
	logic [LAST:1] vld_s;
	php_pkg::div_lane_t dx_s [0:NDIV];
	php_pkg::div_lane_t dy_s [0:NDIV];
	logic behind_s [0:NDIV];
	php_pkg::geo_t g_s35, g_s36, g_s37, g_s38, g_s39, g_s40, g_s41, g_s42, g_s43, g_s44,
		g_s45;
	php_pkg::geo_t n35, n36, n37, n38, n39, n40, n41, n42, n43, n44, n45;
	php_pkg::div_lane_t px_in, py_in;
	logic z_bad;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fx_q <= php_pkg::FOCAL_RST;
			fy_q <= php_pkg::FOCAL_RST;
			cx_q <= '0;
			cy_q <= '0;
			k1_q <= '0;
			k2_q <= '0;
			p1_q <= '0;
			p2_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				php_pkg::REG_FOCAL_X: fx_q <= cfg_data;
				php_pkg::REG_FOCAL_Y: fy_q <= cfg_data;
				php_pkg::REG_CENTRE_X: cx_q <= cfg_data;
				php_pkg::REG_CENTRE_Y: cy_q <= cfg_data;
				php_pkg::REG_RADIAL_K1: k1_q <= cfg_data;
				php_pkg::REG_RADIAL_K2: k2_q <= cfg_data;
				php_pkg::REG_TANG_P1: p1_q <= cfg_data;
				php_pkg::REG_TANG_P2: p2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// global hold when the output is full and stalled
	assign en = !vld_s[LAST] || out_px.ready;
	assign in_pt.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAST-1:1], in_pt.valid};
		end
	end

	// input stage: magnitudes, divisor, early overflow test
	always_comb begin
		z_bad = in_pt.point_z[31] || (in_pt.point_z == 32'sd0);
		px_in.neg = in_pt.point_x[31];
		px_in.mag = in_pt.point_x[31] ? 32'(-in_pt.point_x) : in_pt.point_x;
		px_in.den = z_bad ? 32'd1 : in_pt.point_z;
		px_in.rem = {5'd0, px_in.mag[31:5]};
		px_in.quo = '0;
		px_in.ovf = px_in.rem >= px_in.den;
		py_in.neg = in_pt.point_y[31];
		py_in.mag = in_pt.point_y[31] ? 32'(-in_pt.point_y) : in_pt.point_y;
		py_in.den = px_in.den;
		py_in.rem = {5'd0, py_in.mag[31:5]};
		py_in.quo = '0;
		py_in.ovf = py_in.rem >= py_in.den;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s[0] <= px_in;
			dy_s[0] <= py_in;
			behind_s[0] <= z_bad;
		end
	end

	// restoring divider, one quotient bit per stage, most significant first
	for (genvar k = 1; k <= NDIV; k++) begin : g_div
		localparam int BIT = NDIV - k;
		localparam int MBIT = (BIT >= php_pkg::FRAC) ? BIT - php_pkg::FRAC : 0;
		php_pkg::div_lane_t nx, ny;
		logic [32:0] tx, ty;
		always_comb begin
			nx = dx_s[k-1];
			ny = dy_s[k-1];
			if (BIT >= php_pkg::FRAC) begin
				tx = {nx.rem, nx.mag[MBIT]};
				ty = {ny.rem, ny.mag[MBIT]};
			end else begin
				tx = {nx.rem, 1'b0};
				ty = {ny.rem, 1'b0};
			end
			if (tx >= {1'b0, nx.den}) begin
				nx.rem = 32'(tx - {1'b0, nx.den});
				nx.quo = {nx.quo[NDIV-2:0], 1'b1};
			end else begin
				nx.rem = tx[31:0];
				nx.quo = {nx.quo[NDIV-2:0], 1'b0};
			end
			if (ty >= {1'b0, ny.den}) begin
				ny.rem = 32'(ty - {1'b0, ny.den});
				ny.quo = {ny.quo[NDIV-2:0], 1'b1};
			end else begin
				ny.rem = ty[31:0];
				ny.quo = {ny.quo[NDIV-2:0], 1'b0};
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dx_s[k] <= nx;
				dy_s[k] <= ny;
				behind_s[k] <= behind_s[k-1];
			end
		end
	end

	// distortion and pixel stages
	always_comb begin
		logic [32:0] r0, r1, r2, r3;
		// normalized coordinates
		n35 = '0;
		r0 = php_pkg::div_sat(dx_s[NDIV]);
		r1 = php_pkg::div_sat(dy_s[NDIV]);
		n35.a = r0[31:0];
		n35.b = r1[31:0];
		n35.behind = behind_s[NDIV];
		n35.clip = r0[32] | r1[32];
		// squares and cross term
		n36 = g_s35;
		r0 = php_pkg::mulq(g_s35.a, g_s35.a);
		r1 = php_pkg::mulq(g_s35.b, g_s35.b);
		r2 = php_pkg::mulq(g_s35.a, g_s35.b);
		n36.aa = r0[31:0];
		n36.bb = r1[31:0];
		n36.ab = r2[31:0];
		n36.clip = g_s35.clip | r0[32] | r1[32] | r2[32];
		// r squared
		n37 = g_s36;
		r0 = php_pkg::sat32(php_pkg::sx64(g_s36.aa) + php_pkg::sx64(g_s36.bb));
		n37.r2 = r0[31:0];
		n37.clip = g_s36.clip | r0[32];
		// r4, tangential sums, first products
		n38 = g_s37;
		r0 = php_pkg::mulq(g_s37.r2, g_s37.r2);
		r1 = php_pkg::mulq(k1_q, g_s37.r2);
		r2 = php_pkg::mulq(p1_q, g_s37.ab);
		r3 = php_pkg::mulq(p2_q, g_s37.ab);
		n38.r4 = r0[31:0];
		n38.k1r2 = r1[31:0];
		n38.p1ab = r2[31:0];
		n38.p2ab = r3[31:0];
		n38.clip = g_s37.clip | r0[32] | r1[32] | r2[32] | r3[32];
		r0 = php_pkg::sat32(php_pkg::sx64(g_s37.r2) + 2 * php_pkg::sx64(g_s37.aa));
		r1 = php_pkg::sat32(php_pkg::sx64(g_s37.r2) + 2 * php_pkg::sx64(g_s37.bb));
		n38.sx = r0[31:0];
		n38.sy = r1[31:0];
		n38.clip = n38.clip | r0[32] | r1[32];
		// r6 and the remaining coefficient products
		n39 = g_s38;
		r0 = php_pkg::mulq(g_s38.r4, g_s38.r2);
		r1 = php_pkg::mulq(k2_q, g_s38.r4);
		r2 = php_pkg::mulq(p2_q, g_s38.sx);
		r3 = php_pkg::mulq(p1_q, g_s38.sy);
		n39.r6 = r0[31:0];
		n39.k2r4 = r1[31:0];
		n39.p2sx = r2[31:0];
		n39.p1sy = r3[31:0];
		n39.clip = g_s38.clip | r0[32] | r1[32] | r2[32] | r3[32];
		// third radial term, partial radial sum
		n40 = g_s39;
		r0 = php_pkg::mulq(K3, g_s39.r6);
		n40.k3r6 = r0[31:0];
		n40.sum12 = php_pkg::ONE_Q28 + 35'(g_s39.k1r2) + 35'(g_s39.k2r4);
		n40.clip = g_s39.clip | r0[32];
		// radial factor
		n41 = g_s40;
		r0 = php_pkg::sat32(64'(g_s40.sum12) + php_pkg::sx64(g_s40.k3r6));
		n41.radial = r0[31:0];
		n41.clip = g_s40.clip | r0[32];
		// radial scaling of a and b
		n42 = g_s41;
		r0 = php_pkg::mulq(g_s41.a, g_s41.radial);
		r1 = php_pkg::mulq(g_s41.b, g_s41.radial);
		n42.arad = r0[31:0];
		n42.brad = r1[31:0];
		n42.clip = g_s41.clip | r0[32] | r1[32];
		// distorted coordinates
		n43 = g_s42;
		r0 = php_pkg::sat32(php_pkg::sx64(g_s42.arad) + 2 * php_pkg::sx64(g_s42.p1ab)
			+ php_pkg::sx64(g_s42.p2sx));
		r1 = php_pkg::sat32(php_pkg::sx64(g_s42.brad) + php_pkg::sx64(g_s42.p1sy)
			+ 2 * php_pkg::sx64(g_s42.p2ab));
		n43.xd = r0[31:0];
		n43.yd = r1[31:0];
		n43.clip = g_s42.clip | r0[32] | r1[32];
		// focal scaling
		n44 = g_s43;
		n44.pu = $signed({1'b0, fx_q}) * g_s43.xd;
		n44.pv = $signed({1'b0, fy_q}) * g_s43.yd;
		// principal point offset and behind-camera override
		n45 = g_s44;
		r0 = php_pkg::sat32(64'(g_s44.pu >>> 36) + $signed({40'd0, cx_q[31:8]}));
		r1 = php_pkg::sat32(64'(g_s44.pv >>> 36) + $signed({40'd0, cy_q[31:8]}));
		if (g_s44.behind) begin
			n45.u = '0;
			n45.v = '0;
			n45.clip = 1'b0;
		end else begin
			n45.u = r0[31:0];
			n45.v = r1[31:0];
			n45.clip = g_s44.clip | r0[32] | r1[32];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g_s35 <= n35;
			g_s36 <= n36;
			g_s37 <= n37;
			g_s38 <= n38;
			g_s39 <= n39;
			g_s40 <= n40;
			g_s41 <= n41;
			g_s42 <= n42;
			g_s43 <= n43;
			g_s44 <= n44;
			g_s45 <= n45;
		end
	end

	// result transaction
	assign out_px.valid = vld_s[LAST];
	assign out_px.pixel_u = g_s45.u;
	assign out_px.pixel_v = g_s45.v;
	assign out_px.behind_camera = g_s45.behind;
	assign out_px.clipped = g_s45.clip;

endmodule

FILE: verif/pinhole_projection_with_distortion_top_tb.sv
// testbench for the pinhole projection block: random and directed points checked against a predictor
module pinhole_projection_with_distortion_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int K3 = 0;
	localparam int DRAIN_CYCLES = 60;

	typedef struct {
		logic signed [31:0] u;
		logic signed [31:0] v;
		bit behind;
		bit clip;
	} pixel_t;

	// predicts projected pixels and compares them with what the block delivers
	class pixel_scoreboard;
		logic [31:0] regs [php_pkg::NUM_REGS];
		pixel_t pending[$];
		int errors;
		int checked;
		int behind_seen;
		int clip_seen;

		function new();
			foreach (regs[i]) regs[i] = 32'd0;
			regs[php_pkg::REG_FOCAL_X] = php_pkg::FOCAL_RST;
			regs[php_pkg::REG_FOCAL_Y] = php_pkg::FOCAL_RST;
			errors = 0;
			checked = 0;
			behind_seen = 0;
			clip_seen = 0;
		endfunction

		function longint clamp(longint v, inout bit c);
			if (v > 64'sd2147483647) begin
				c = 1;
				return 64'sd2147483647;
			end
			if (v < -64'sd2147483648) begin
				c = 1;
				return -64'sd2147483648;
			end
			return v;
		endfunction

		// Q4.28 product rounded toward minus infinity
		function longint qmul(longint x, longint y, inout bit c);
			return clamp((x * y) >>> 28, c);
		endfunction

		function longint to_pixel(logic [31:0] focal, logic [31:0] centre, longint d, inout bit c);
			longint f;
			longint p;
			f = longint'({32'd0, focal});
			p = (f * d) >>> 36;
			return clamp(p + longint'({40'd0, centre[31:8]}), c);
		endfunction

		function pixel_t project(logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z);
			pixel_t r;
			bit c;
			longint px, py, pz, k1, k2, p1, p2, k3;
			longint a, b, aa, bb, ab, r2, r4, r6, radial, sx, sy, xd, yd;
			px = x;
			py = y;
			pz = z;
			c = 0;
			r.behind = 0;
			// depth at or below zero gives zero pixels and no clip flag
			if (pz <= 0) begin
				r.u = 0;
				r.v = 0;
				r.behind = 1;
				r.clip = 0;
				return r;
			end
			k1 = longint'(signed'(regs[php_pkg::REG_RADIAL_K1]));
			k2 = longint'(signed'(regs[php_pkg::REG_RADIAL_K2]));
			p1 = longint'(signed'(regs[php_pkg::REG_TANG_P1]));
			p2 = longint'(signed'(regs[php_pkg::REG_TANG_P2]));
			k3 = K3;
			a = clamp((px * (64'sd1 <<< 28)) / pz, c);
			b = clamp((py * (64'sd1 <<< 28)) / pz, c);
			aa = qmul(a, a, c);
			bb = qmul(b, b, c);
			ab = qmul(a, b, c);
			r2 = clamp(aa + bb, c);
			r4 = qmul(r2, r2, c);
			r6 = qmul(r4, r2, c);
			radial = clamp((64'sd1 <<< 28) + qmul(k1, r2, c) + qmul(k2, r4, c)
				+ qmul(k3, r6, c), c);
			sx = clamp(r2 + 2 * aa, c);
			sy = clamp(r2 + 2 * bb, c);
			xd = clamp(qmul(a, radial, c) + 2 * qmul(p1, ab, c) + qmul(p2, sx, c), c);
			yd = clamp(qmul(b, radial, c) + qmul(p1, sy, c) + 2 * qmul(p2, ab, c), c);
			r.u = 32'(to_pixel(regs[php_pkg::REG_FOCAL_X], regs[php_pkg::REG_CENTRE_X], xd, c));
			r.v = 32'(to_pixel(regs[php_pkg::REG_FOCAL_Y], regs[php_pkg::REG_CENTRE_Y], yd, c));
			r.clip = c;
			return r;
		endfunction

		function void note_point(logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z);
			pending = {pending, project(x, y, z)};
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			errors++;
			$display("mismatch %s: got %h expected %h (result %0d)", what, got, want, checked);
		endtask

		task check_pixel(logic signed [31:0] u, logic signed [31:0] v, logic bh, logic cl);
			pixel_t e;
			if (pending.size() == 0) begin
				report("unexpected transaction", u, 0);
				return;
			end
			e = pending.pop_front();
			if (u !== e.u) report("pixel_u", u, e.u);
			if (v !== e.v) report("pixel_v", v, e.v);
			if (bh !== e.behind) report("behind_camera", bh, e.behind);
			if (cl !== e.clip) report("clipped", cl, e.clip);
			if (e.behind) behind_seen++;
			if (e.clip) clip_seen++;
			checked++;
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [php_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;
	php_pt_if in_pt();
	php_px_if out_px();

	pixel_scoreboard sb;
	int send_idle;
	int recv_stall;
	int hold_left;
	int sent;

	pinhole_projection_with_distortion_top #(.RADIAL_K3(K3)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_pt(in_pt.sink),
		.out_px(out_px.source)
	);

	// clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// run limit
	initial begin
		#2_000_000;
		$display("timeout with %0d results outstanding", sb.pending.size());
		$display("** pinhole_projection_with_distortion_top: FAILED **");
		$finish;
	end

	// receiver: random stalls plus an optional long hold-off
	initial begin
		out_px.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_px.valid && out_px.ready)
				sb.check_pixel(out_px.pixel_u, out_px.pixel_v, out_px.behind_camera,
					out_px.clipped);
			if (hold_left > 0) begin
				hold_left--;
				out_px.ready <= 1'b0;
			end else begin
				out_px.ready <= ($urandom_range(99) >= recv_stall);
			end
		end
	end

	// one register write; the write enable is dropped again before the task returns
	task write_reg(logic [php_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.regs[idx] = data;
		@(posedge clk);
	endtask

	// offer one point, with random idle cycles ahead of it
	task send_point(logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z);
		while ($urandom_range(99) < send_idle) begin
			in_pt.valid <= 1'b0;
			@(posedge clk);
		end
		in_pt.valid <= 1'b1;
		in_pt.point_x <= x;
		in_pt.point_y <= y;
		in_pt.point_z <= z;
		do @(posedge clk); while (!in_pt.ready);
		sb.note_point(x, y, z);
		sent++;
	endtask

	task drain();
		in_pt.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// mostly points in front of the camera within a sane field of view, some raw noise
	task send_random_point();
		logic signed [31:0] z;
		logic signed [31:0] x;
		logic signed [31:0] y;
		int sel;
		sel = $urandom_range(99);
		if (sel < 12) begin
			send_point($urandom, $urandom, $urandom);
		end else begin
			z = $urandom_range(32'h0100_0000, 1);
			x = $urandom_range(32'(z) * 2, 0);
			y = $urandom_range(32'(z) * 2, 0);
			if ($urandom_range(1)) x = -x;
			if ($urandom_range(1)) y = -y;
			if (sel < 20) z = -z;
			send_point(x, y, z);
		end
	endtask

	// calibration setting for one phase: extremes on two phases, plausible values elsewhere
	task load_setting(int ph);
		logic [31:0] k;
		case (ph)
			1: begin
				for (int i = 0; i < php_pkg::NUM_REGS; i++) begin
					k = (i < 4) ? 32'hffff_ffff : 32'h7fff_ffff;
					write_reg(php_pkg::CFG_IDX_W'(i), k);
				end
			end
			2: begin
				for (int i = 0; i < php_pkg::NUM_REGS; i++) begin
					k = (i < 4) ? 32'h0 : 32'h8000_0000;
					write_reg(php_pkg::CFG_IDX_W'(i), k);
				end
			end
			default: begin
				write_reg(php_pkg::REG_FOCAL_X, $urandom_range(32'h0800_0000, 32'h0001_0000));
				write_reg(php_pkg::REG_FOCAL_Y, $urandom_range(32'h0800_0000, 32'h0001_0000));
				write_reg(php_pkg::REG_CENTRE_X, $urandom_range(32'h0800_0000, 0));
				write_reg(php_pkg::REG_CENTRE_Y, $urandom_range(32'h0800_0000, 0));
				write_reg(php_pkg::REG_RADIAL_K1,
					$urandom_range(32'h1000_0000, 0) - 32'h0800_0000);
				write_reg(php_pkg::REG_RADIAL_K2,
					$urandom_range(32'h0800_0000, 0) - 32'h0400_0000);
				write_reg(php_pkg::REG_TANG_P1,
					$urandom_range(32'h0040_0000, 0) - 32'h0020_0000);
				write_reg(php_pkg::REG_TANG_P2,
					$urandom_range(32'h0040_0000, 0) - 32'h0020_0000);
			end
		endcase
	endtask

	// main sequence
	initial begin
		sb = new();
		send_idle = 0;
		recv_stall = 0;
		hold_left = 0;
		sent = 0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_pt.valid <= 1'b0;
		in_pt.point_x <= '0;
		in_pt.point_y <= '0;
		in_pt.point_z <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed points at reset calibration, then with strong distortion
		for (int pass = 0; pass < 2; pass++) begin
			if (pass == 1) begin
				drain();
				write_reg(php_pkg::REG_RADIAL_K1, 32'h0400_0000);
				write_reg(php_pkg::REG_RADIAL_K2, 32'hfe00_0000);
				write_reg(php_pkg::REG_TANG_P1, 32'h0010_0000);
				write_reg(php_pkg::REG_TANG_P2, 32'hfff0_0000);
				write_reg(php_pkg::REG_FOCAL_X, 32'h0200_0000);
				write_reg(php_pkg::REG_CENTRE_Y, 32'h0140_0000);
			end
			send_point(0, 0, 256);
			send_point(256, -256, 512);
			send_point(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
			send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff);
			// depth zero and negative
			send_point(100, 100, 0);
			send_point(100, 100, -1);
			send_point(32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000);
			// ratio too large for Q4.28
			send_point(32'sh7fff_ffff, 0, 1);
			send_point(0, 32'sh8000_0000, 1);
			send_point(2048, -4096, 256);
			send_point(-1, 1, 1);
		end
		drain();

		// random phases over settings and idle patterns
		for (int ph = 0; ph < 8; ph++) begin
			load_setting(ph);
			case (ph % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 71; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 71; end
				default: begin send_idle = 13; recv_stall = 13; end
			endcase
			if (ph == 3) hold_left = 400;
			for (int n = 0; n < 200; n++) begin
				if (ph == 5 && n == 100) begin
					in_pt.valid <= 1'b0;
					while (sb.pending.size() != 0) @(posedge clk);
				end
				send_random_point();
			end
			drain();
		end

		$display("sent %0d points, checked %0d pixels (%0d behind camera, %0d clipped)",
			sent, sb.checked, sb.behind_seen, sb.clip_seen);
		$display("covered reset, extreme and random calibrations under four flow-control mixes");
		if (sb.errors == 0) begin
			$display("** pinhole_projection_with_distortion_top: PASSED **");
		end else begin
			$display("** pinhole_projection_with_distortion_top: FAILED **");
		end
		$finish;
	end

endmodule
